/* rtl/rarst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rarst_pkg
// Shared types and constants for the range-add / range-sum lazy segment tree.
// ----------------------------------------------------------------------------
package rarst_pkg;

    localparam int VALUE_W = 64;
    localparam int HALF_W  = 32;
    localparam int INDEX_W = 16;
    localparam int COUNT_W = 11;
    localparam int OP_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_ADD   = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_ENTER,
        S_LEAF_WR,
        S_QACC,
        S_SPREAD,
        S_SPREAD_R,
        S_SPREAD_CLR,
        S_DESC_L,
        S_DESC_R,
        S_COMB0,
        S_COMB1,
        S_COMB2,
        S_RET,
        S_AP_MUL0,
        S_AP_MUL1,
        S_AP_ADD,
        S_AP_SUMW,
        S_AP_TAGW,
        S_DONE
    } t_state;

endpackage

/* rtl/range_add_range_sum_tree_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_add_range_sum_tree_unit
// Lazy segment tree over up to MAX_ELEMENTS 64-bit elements: load, build,
// range add and range sum, one result beat per operation.
// ----------------------------------------------------------------------------
// Operations run one at a time under a small sequencer that walks the tree with
// an explicit frame stack and single-port node and tag memories. In an add or
// query, a pushed-down tag takes two apply passes through the shared multiplier
// and a full-cover add takes one. A build first sweeps the tag memory, then
// fills the 2n-1 nodes. After reset the tag memory is swept the same way before
// the first beat is taken.
// Configuration beats are taken at any time.
// ----------------------------------------------------------------------------
module range_add_range_sum_tree_unit
    import rarst_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024,
    parameter int NODE_COUNT   = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [COUNT_W-1:0] i_cfg_element_count,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [INDEX_W-1:0] i_first_index,
    input  logic [INDEX_W-1:0] i_last_index,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [VALUE_W-1:0] o_range_sum,
    output logic               o_range_rejected
);

    localparam int IXW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW  = $clog2(MAX_ELEMENTS + 1);
    localparam int AW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int KW0 = IXW + 3;
    localparam int KW  = (KW0 > AW + 1) ? KW0 : AW + 1;
    localparam int SD  = IXW + 1;
    localparam int SIW = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);

    typedef struct packed {
        logic [KW-1:0]  k;
        logic [IXW-1:0] lo;
        logic [IXW-1:0] hi;
        logic           ph;
    } t_frame;

    function automatic logic node_ok(input logic [KW-1:0] k);
        node_ok = (k < KW'(NODE_COUNT));
    endfunction

    // control
    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr, n_clr;
    logic               r_build, n_build;
    logic [SPW-1:0]     r_sp, n_sp;
    logic               r_o_valid, n_o_valid;
    logic [COUNT_W-1:0] r_count;

    // payload
    t_op                r_op, n_op;
    logic [IXW-1:0]     r_a, n_a;
    logic [IXW-1:0]     r_b, n_b;
    logic [VALUE_W-1:0] r_v, n_v;
    logic [VALUE_W-1:0] r_acc, n_acc;
    logic               r_rej, n_rej;
    logic [KW-1:0]      r_k, n_k;
    logic [IXW-1:0]     r_lo, n_lo;
    logic [IXW-1:0]     r_hi, n_hi;
    logic [KW-1:0]      r_ak, n_ak;
    logic [CW-1:0]      r_alen, n_alen;
    logic [VALUE_W-1:0] r_av, n_av;
    t_state             r_ret, n_ret;
    logic [VALUE_W-1:0] r_plo, n_plo;
    logic [VALUE_W-1:0] r_tmp, n_tmp;
    logic [VALUE_W-1:0] r_o_sum, n_o_sum;
    logic               r_o_rej, n_o_rej;

    // memories
    logic [VALUE_W-1:0] r_leaf_mem [MAX_ELEMENTS];
    logic [VALUE_W-1:0] r_sum_mem  [NODE_COUNT];
    logic [VALUE_W-1:0] r_tag_mem  [NODE_COUNT];
    logic [VALUE_W-1:0] r_leaf_rd;
    logic [VALUE_W-1:0] r_sum_rd;
    logic [VALUE_W-1:0] r_tag_rd;
    logic               r_sum_ok;
    logic               r_tag_ok;
    t_frame             r_stk [SD];

    logic               w_leaf_re, w_leaf_we;
    logic               w_sum_re, w_sum_we, w_tag_re, w_tag_we;
    logic [KW-1:0]      w_sum_rk, w_sum_wk, w_tag_rk, w_tag_wk;
    logic [VALUE_W-1:0] w_sum_wd, w_tag_wd;
    logic [VALUE_W-1:0] w_sum_rdata, w_tag_rdata;
    logic               w_push_en, w_push_ph;
    logic               w_mul_en;
    logic [HALF_W-1:0]  w_mul_a;
    logic [HALF_W+CW-1:0] w_mul_p;

    logic [CW-1:0]      w_n;
    logic [IXW-1:0]     w_last;
    logic               w_a_in;
    logic               w_bad;
    logic [IXW-1:0]     w_b_clamp;
    logic [IXW:0]       w_lh;
    logic [IXW-1:0]     w_mid;
    logic [KW-1:0]      w_kl, w_kr;
    logic [CW-1:0]      w_len, w_len_l, w_len_r;
    logic               w_cover;
    logic [SPW-1:0]     w_sp_m1;
    t_frame             w_top;
    logic               w_is_build;

    assign o_cfg_ready = 1'b1;

    assign w_n = (32'(r_count) > 32'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS) : CW'(r_count);
    assign w_last = IXW'(w_n - CW'(1));
    assign w_a_in = (32'(i_first_index) < 32'(w_n));
    assign w_bad = (i_first_index > i_last_index) || !w_a_in;
    assign w_b_clamp = (32'(i_last_index) > 32'(w_last)) ? w_last : IXW'(i_last_index);

    assign w_lh    = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid   = w_lh[IXW:1];
    assign w_kl    = {r_k[KW-2:0], 1'b0};
    assign w_kr    = {r_k[KW-2:0], 1'b1};
    assign w_len   = CW'(r_hi) - CW'(r_lo) + CW'(1);
    assign w_len_l = CW'(w_mid) - CW'(r_lo) + CW'(1);
    assign w_len_r = CW'(r_hi) - CW'(w_mid);
    assign w_cover = (r_a <= r_lo) && (r_hi <= r_b);
    assign w_is_build = (r_op == OP_BUILD);

    assign w_sp_m1 = r_sp - SPW'(1);
    assign w_top   = r_stk[w_sp_m1[SIW-1:0]];

    assign w_sum_rdata = r_sum_ok ? r_sum_rd : '0;
    assign w_tag_rdata = r_tag_ok ? r_tag_rd : '0;

    rarst_mul #(
        .B_W(CW)
    ) u_mul (
        .i_clk(i_clk),
        .i_en (w_mul_en),
        .i_a  (w_mul_a),
        .i_b  (r_alen),
        .o_p  (w_mul_p)
    );

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_build   = r_build;
        n_sp      = r_sp;
        n_o_valid = r_o_valid & ~i_ready;
        n_op      = r_op;
        n_a       = r_a;
        n_b       = r_b;
        n_v       = r_v;
        n_acc     = r_acc;
        n_rej     = r_rej;
        n_k       = r_k;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_ak      = r_ak;
        n_alen    = r_alen;
        n_av      = r_av;
        n_ret     = r_ret;
        n_plo     = r_plo;
        n_tmp     = r_tmp;
        n_o_sum   = r_o_sum;
        n_o_rej   = r_o_rej;
        w_push_en = 1'b0;
        w_push_ph = 1'b0;
        w_leaf_re = 1'b0;
        w_leaf_we = 1'b0;
        w_sum_re  = 1'b0;
        w_sum_rk  = r_k;
        w_sum_we  = 1'b0;
        w_sum_wk  = r_k;
        w_sum_wd  = r_tmp;
        w_tag_re  = 1'b0;
        w_tag_rk  = r_k;
        w_tag_we  = 1'b0;
        w_tag_wk  = r_k;
        w_tag_wd  = '0;
        w_mul_en  = 1'b0;
        w_mul_a   = r_av[HALF_W-1:0];
        o_ready   = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_tag_we = 1'b1;
                w_tag_wk = KW'(r_clr);
                n_clr    = r_clr + AW'(1);
                if (r_clr == AW'(NODE_COUNT - 1)) begin
                    n_clr = '0;
                    if (r_build) begin
                        n_build = 1'b0;
                        n_state = S_ENTER;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_op  = t_op'(i_operation);
                    n_acc = '0;
                    n_rej = 1'b0;
                    n_a   = IXW'(i_first_index);
                    n_b   = w_b_clamp;
                    n_v   = i_value;
                    n_k   = KW'(1);
                    n_lo  = '0;
                    n_hi  = w_last;
                    n_sp  = '0;
                    if (w_n == '0) begin
                        n_rej   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        unique case (t_op'(i_operation))
                            OP_LOAD: begin
                                w_leaf_we = w_a_in;
                                n_rej     = ~w_a_in;
                                n_state   = S_DONE;
                            end
                            OP_BUILD: begin
                                n_build = 1'b1;
                                n_clr   = '0;
                                n_state = S_CLEAR;
                            end
                            default: begin
                                if (w_bad) begin
                                    n_rej   = 1'b1;
                                    n_state = S_DONE;
                                end else begin
                                    n_state = S_ENTER;
                                end
                            end
                        endcase
                    end
                end
            end
            S_ENTER: begin
                if (w_is_build) begin
                    if (r_lo == r_hi) begin
                        w_leaf_re = 1'b1;
                        n_state   = S_LEAF_WR;
                    end else begin
                        n_state = S_DESC_L;
                    end
                end else if (w_cover) begin
                    if (r_op == OP_ADD) begin
                        n_ak    = r_k;
                        n_alen  = w_len;
                        n_av    = r_v;
                        n_ret   = S_RET;
                        n_state = S_AP_MUL0;
                    end else begin
                        w_sum_re = 1'b1;
                        n_state  = S_QACC;
                    end
                end else begin
                    w_tag_re = 1'b1;
                    n_state  = S_SPREAD;
                end
            end
            S_LEAF_WR: begin
                w_sum_we = node_ok(r_k);
                w_sum_wd = r_leaf_rd;
                n_state  = S_RET;
            end
            S_QACC: begin
                n_acc   = r_acc + w_sum_rdata;
                n_state = S_RET;
            end
            S_SPREAD: begin
                if (w_tag_rdata == '0) begin
                    n_state = S_DESC_L;
                end else begin
                    n_av    = w_tag_rdata;
                    n_ak    = w_kl;
                    n_alen  = w_len_l;
                    n_ret   = S_SPREAD_R;
                    n_state = S_AP_MUL0;
                end
            end
            S_SPREAD_R: begin
                n_ak    = w_kr;
                n_alen  = w_len_r;
                n_ret   = S_SPREAD_CLR;
                n_state = S_AP_MUL0;
            end
            S_SPREAD_CLR: begin
                w_tag_we = node_ok(r_k);
                n_state  = S_DESC_L;
            end
            S_DESC_L: begin
                if (w_is_build || (r_a <= w_mid)) begin
                    w_push_en = 1'b1;
                    n_sp      = r_sp + SPW'(1);
                    n_k       = w_kl;
                    n_hi      = w_mid;
                    n_state   = S_ENTER;
                end else begin
                    n_state = S_DESC_R;
                end
            end
            S_DESC_R: begin
                if (w_is_build || (r_b > w_mid)) begin
                    w_push_en = 1'b1;
                    w_push_ph = 1'b1;
                    n_sp      = r_sp + SPW'(1);
                    n_k       = w_kr;
                    n_lo      = w_mid + IXW'(1);
                    n_state   = S_ENTER;
                end else begin
                    n_state = S_COMB0;
                end
            end
            S_COMB0: begin
                if (r_op == OP_QUERY) begin
                    n_state = S_RET;
                end else begin
                    w_sum_re = 1'b1;
                    w_sum_rk = w_kl;
                    n_state  = S_COMB1;
                end
            end
            S_COMB1: begin
                w_sum_re = 1'b1;
                w_sum_rk = w_kr;
                n_tmp    = w_sum_rdata;
                n_state  = S_COMB2;
            end
            S_COMB2: begin
                w_sum_we = node_ok(r_k);
                w_sum_wd = r_tmp + w_sum_rdata;
                n_state  = S_RET;
            end
            S_RET: begin
                if (r_sp == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_sp    = w_sp_m1;
                    n_k     = w_top.k;
                    n_lo    = w_top.lo;
                    n_hi    = w_top.hi;
                    n_state = w_top.ph ? S_COMB0 : S_DESC_R;
                end
            end
            S_AP_MUL0: begin
                w_sum_re = 1'b1;
                w_sum_rk = r_ak;
                w_mul_en = 1'b1;
                n_state  = S_AP_MUL1;
            end
            S_AP_MUL1: begin
                w_mul_en = 1'b1;
                w_mul_a  = r_av[VALUE_W-1:HALF_W];
                n_plo    = VALUE_W'(w_mul_p);
                n_state  = S_AP_ADD;
            end
            S_AP_ADD: begin
                n_tmp   = w_sum_rdata + r_plo;
                n_state = S_AP_SUMW;
            end
            S_AP_SUMW: begin
                w_sum_we = node_ok(r_ak);
                w_sum_wk = r_ak;
                w_sum_wd = r_tmp + {w_mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
                w_tag_re = 1'b1;
                w_tag_rk = r_ak;
                n_state  = S_AP_TAGW;
            end
            S_AP_TAGW: begin
                w_tag_we = node_ok(r_ak);
                w_tag_wk = r_ak;
                w_tag_wd = w_tag_rdata + r_av;
                n_state  = r_ret;
            end
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_sum   = r_acc;
                    n_o_rej   = r_rej;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_build   <= 1'b0;
            r_sp      <= '0;
            r_o_valid <= 1'b0;
            r_count   <= '0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_build   <= n_build;
            r_sp      <= n_sp;
            r_o_valid <= n_o_valid;
            if (i_cfg_valid) begin
                r_count <= i_cfg_element_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_a     <= n_a;
        r_b     <= n_b;
        r_v     <= n_v;
        r_acc   <= n_acc;
        r_rej   <= n_rej;
        r_k     <= n_k;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_ak    <= n_ak;
        r_alen  <= n_alen;
        r_av    <= n_av;
        r_ret   <= n_ret;
        r_plo   <= n_plo;
        r_tmp   <= n_tmp;
        r_o_sum <= n_o_sum;
        r_o_rej <= n_o_rej;
        if (w_push_en) begin
            r_stk[r_sp[SIW-1:0]] <= '{k: r_k, lo: r_lo, hi: r_hi, ph: w_push_ph};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_leaf_we) begin
            r_leaf_mem[IXW'(i_first_index)] <= i_value;
        end
        if (w_leaf_re) begin
            r_leaf_rd <= r_leaf_mem[r_lo];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sum_we) begin
            r_sum_mem[w_sum_wk[AW-1:0]] <= w_sum_wd;
        end
        if (w_sum_re) begin
            r_sum_rd <= r_sum_mem[w_sum_rk[AW-1:0]];
            r_sum_ok <= node_ok(w_sum_rk);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tag_we) begin
            r_tag_mem[w_tag_wk[AW-1:0]] <= w_tag_wd;
        end
        if (w_tag_re) begin
            r_tag_rd <= r_tag_mem[w_tag_rk[AW-1:0]];
            r_tag_ok <= node_ok(w_tag_rk);
        end
    end

    assign o_valid          = r_o_valid;
    assign o_range_sum      = r_o_sum;
    assign o_range_rejected = r_o_rej;

endmodule

/* rtl/rarst_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rarst_mul
// Registered 32-bit by segment-length multiplier shared by every tag apply.
// ----------------------------------------------------------------------------
module rarst_mul
    import rarst_pkg::*;
#(
    parameter int B_W = 11
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [HALF_W-1:0]     i_a,
    input  logic [B_W-1:0]        i_b,
    output logic [HALF_W+B_W-1:0] o_p
);

    logic [HALF_W+B_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= (HALF_W+B_W)'(i_a) * (HALF_W+B_W)'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

/* rtl/rarst_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rarst_checker
// Port-level checks for the range-add / range-sum tree unit.
// ----------------------------------------------------------------------------
module rarst_checker
    import rarst_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic [VALUE_W-1:0] o_range_sum,
    input logic               o_range_rejected
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_range_sum))
        else $error("result beat dropped or changed while stalled");

    a_rej_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_range_rejected |-> o_range_sum == '0)
        else $error("rejected beat carries a nonzero sum");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after an accepted beat");

    a_sweep_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("ready high right after reset");

endmodule

bind range_add_range_sum_tree_unit rarst_checker u_rarst_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_range_sum     (o_range_sum),
    .o_range_rejected(o_range_rejected)
);
